@@ src/tlw_pkg.sv @@
`timescale 1ns / 1ps

package tlw_pkg;

    localparam int CFG_W          = 31;
    localparam int CFG_IDX_W      = 3;
    localparam int COUNT_BITS_DEF = 31;
    localparam int REQ_W          = 2;
    localparam int KIND_W         = 3;
    localparam int CODE_W         = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_DATA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REKEY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SSL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE     = 3'd7;

    localparam logic [REQ_W-1:0] REQ_POLL    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SENT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INBOUND = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

    localparam logic [KIND_W-1:0] KIND_DPD_REQUEST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMPRESSED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DISCONNECT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TERMINATE   = 3'd6;

    localparam logic [CODE_W-1:0] END_NONE          = 4'd0;
    localparam logic [CODE_W-1:0] END_SESSION       = 4'd1;
    localparam logic [CODE_W-1:0] END_IDLE          = 4'd2;
    localparam logic [CODE_W-1:0] END_REKEY_UNSUPP  = 4'd3;
    localparam logic [CODE_W-1:0] END_REKEY_RECONN  = 4'd4;
    localparam logic [CODE_W-1:0] END_DEAD_PEER     = 4'd5;
    localparam logic [CODE_W-1:0] END_NO_DATA       = 4'd6;
    localparam logic [CODE_W-1:0] END_COMPRESSED    = 4'd7;
    localparam logic [CODE_W-1:0] END_DISCONNECTED  = 4'd8;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

@@ src/tlw_ctrl.sv @@
`timescale 1ns / 1ps

module tlw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tlw_pkg::t_status i_status,
    output tlw_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (!i_status.need_div) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ src/tlw_datapath.sv @@
`timescale 1ns / 1ps

module tlw_datapath #(
    parameter int COUNT_BITS = tlw_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tlw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlw_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [tlw_pkg::REQ_W-1:0]      i_req_type,
    input  logic [tlw_pkg::KIND_W-1:0]     i_frame_kind,
    input  tlw_pkg::t_cmd                  i_cmd,
    output tlw_pkg::t_status               o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_send_keepalive,
    output logic                           o_send_probe,
    output logic                           o_send_probe_reply,
    output logic                           o_session_ended,
    output logic [tlw_pkg::CODE_W-1:0]     o_end_code,
    output logic                           o_reconnect_eligible,
    output logic                           o_is_stopped
);

    localparam int CFG_W = tlw_pkg::CFG_W;
    localparam int BIT_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [BIT_W-1:0]      BIT_LAST = BIT_W'(COUNT_BITS - 1);

    // configuration
    logic [CFG_W-1:0] r_no_data;
    logic [CFG_W-1:0] r_session;
    logic [CFG_W-1:0] r_idle_to;
    logic [CFG_W-1:0] r_rekey;
    logic             r_ssl;
    logic [CFG_W-1:0] r_budget;
    logic [CFG_W-1:0] r_keepalive;
    logic [CFG_W-1:0] r_probe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_data   <= '0;
            r_session   <= '0;
            r_idle_to   <= '0;
            r_rekey     <= '0;
            r_ssl       <= 1'b0;
            r_budget    <= '0;
            r_keepalive <= '0;
            r_probe     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlw_pkg::CFG_NO_DATA:   r_no_data   <= i_cfg_data;
                tlw_pkg::CFG_SESSION:   r_session   <= i_cfg_data;
                tlw_pkg::CFG_IDLE:      r_idle_to   <= i_cfg_data;
                tlw_pkg::CFG_REKEY:     r_rekey     <= i_cfg_data;
                tlw_pkg::CFG_SSL:       r_ssl       <= i_cfg_data[0];
                tlw_pkg::CFG_BUDGET:    r_budget    <= i_cfg_data;
                tlw_pkg::CFG_KEEPALIVE: r_keepalive <= i_cfg_data;
                tlw_pkg::CFG_PROBE:     r_probe     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // session state
    logic [COUNT_BITS-1:0] r_idle;
    logic [COUNT_BITS-1:0] n_idle;
    logic                  r_rekey_pend;
    logic                  n_rekey_pend;
    logic                  r_probe_out;
    logic                  n_probe_out;
    logic                  r_activity;
    logic                  n_activity;
    logic [COUNT_BITS-1:0] r_probe_wait;
    logic [COUNT_BITS-1:0] n_probe_wait;
    logic                  r_stopped;
    logic                  n_stopped;

    // item and working registers
    logic [tlw_pkg::REQ_W-1:0]  r_req;
    logic [tlw_pkg::REQ_W-1:0]  n_req;
    logic [tlw_pkg::KIND_W-1:0] r_kind;
    logic [tlw_pkg::KIND_W-1:0] n_kind;
    logic                       r_need_div;
    logic                       n_need_div;
    logic [BIT_W-1:0]           r_bit;
    logic [BIT_W-1:0]           n_bit;
    logic [CFG_W-1:0]           r_rem_k;
    logic [CFG_W-1:0]           n_rem_k;
    logic [CFG_W-1:0]           r_rem_p;
    logic [CFG_W-1:0]           n_rem_p;

    // pending result
    logic                       r_res_ka;
    logic                       n_res_ka;
    logic                       r_res_pr;
    logic                       n_res_pr;
    logic                       r_res_reply;
    logic                       n_res_reply;
    logic [tlw_pkg::CODE_W-1:0] r_res_code;
    logic [tlw_pkg::CODE_W-1:0] n_res_code;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] pw_inc;
    logic [CFG_W-1:0]      cnt_ext;
    logic [CFG_W-1:0]      pw_ext;
    logic [CFG_W:0]        trial_k;
    logic [CFG_W:0]        trial_p;

    assign cnt_inc = (r_idle == CNT_MAX) ? r_idle : r_idle + 1'b1;
    assign pw_inc  = (r_probe_wait == CNT_MAX) ? r_probe_wait : r_probe_wait + 1'b1;
    assign cnt_ext = CFG_W'(cnt_inc);
    assign pw_ext  = CFG_W'(pw_inc);
    assign trial_k = {r_rem_k, r_idle[r_bit]};
    assign trial_p = {r_rem_p, r_idle[r_bit]};

    always_comb begin
        logic [tlw_pkg::CODE_W-1:0] v_code;
        v_code       = tlw_pkg::END_NONE;
        n_idle       = r_idle;
        n_rekey_pend = r_rekey_pend;
        n_probe_out  = r_probe_out;
        n_activity   = r_activity;
        n_probe_wait = r_probe_wait;
        n_stopped    = r_stopped;
        n_req        = r_req;
        n_kind       = r_kind;
        n_need_div   = r_need_div;
        n_bit        = r_bit;
        n_rem_k      = r_rem_k;
        n_rem_p      = r_rem_p;
        n_res_ka     = r_res_ka;
        n_res_pr     = r_res_pr;
        n_res_reply  = r_res_reply;
        n_res_code   = r_res_code;

        if (i_cmd.load) begin
            n_req  = i_req_type;
            n_kind = i_frame_kind;
        end

        if (i_cmd.eval) begin
            n_res_ka    = 1'b0;
            n_res_pr    = 1'b0;
            n_res_reply = 1'b0;
            n_need_div  = 1'b0;
            if (r_req == tlw_pkg::REQ_RESTART) begin
                n_idle       = '0;
                n_rekey_pend = 1'b0;
                n_probe_out  = 1'b0;
                n_activity   = 1'b0;
                n_probe_wait = '0;
                n_stopped    = 1'b0;
            end else if (!r_stopped) begin
                unique case (r_req)
                    tlw_pkg::REQ_POLL: begin
                        n_idle = cnt_inc;
                        if (cnt_ext > r_no_data) begin
                            v_code = tlw_pkg::END_NO_DATA;
                        end else if (r_session != '0 && cnt_ext >= r_session) begin
                            v_code = tlw_pkg::END_SESSION;
                        end else if (r_idle_to != '0 && cnt_ext >= r_idle_to) begin
                            v_code = tlw_pkg::END_IDLE;
                        end else if (!r_rekey_pend && r_rekey != '0
                                     && cnt_ext >= r_rekey) begin
                            n_rekey_pend = 1'b1;
                            v_code = r_ssl ? tlw_pkg::END_REKEY_UNSUPP
                                           : tlw_pkg::END_REKEY_RECONN;
                        end else if (r_probe_out && r_activity) begin
                            n_probe_out  = 1'b0;
                            n_probe_wait = '0;
                        end else if (r_probe_out && r_budget != '0) begin
                            n_probe_wait = pw_inc;
                            if (pw_ext >= r_budget) begin
                                v_code = tlw_pkg::END_DEAD_PEER;
                            end
                        end
                        if (v_code == tlw_pkg::END_NONE) begin
                            n_need_div = 1'b1;
                            n_bit      = BIT_LAST;
                            n_rem_k    = '0;
                            n_rem_p    = '0;
                        end
                    end
                    tlw_pkg::REQ_SENT: begin
                        n_idle = '0;
                    end
                    tlw_pkg::REQ_INBOUND: begin
                        n_activity = 1'b1;
                        case (r_kind) inside
                            tlw_pkg::KIND_DPD_REQUEST: n_res_reply = 1'b1;
                            tlw_pkg::KIND_COMPRESSED:  v_code = tlw_pkg::END_COMPRESSED;
                            tlw_pkg::KIND_DISCONNECT,
                            tlw_pkg::KIND_TERMINATE:   v_code = tlw_pkg::END_DISCONNECTED;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                if (v_code != tlw_pkg::END_NONE) begin
                    n_stopped = 1'b1;
                end
            end
            n_res_code = v_code;
        end

        // restoring remainder, one dividend bit per step for both intervals
        if (i_cmd.div_step) begin
            n_bit = r_bit - 1'b1;
            if (trial_k >= {1'b0, r_keepalive}) begin
                n_rem_k = CFG_W'(trial_k - {1'b0, r_keepalive});
            end else begin
                n_rem_k = CFG_W'(trial_k);
            end
            if (trial_p >= {1'b0, r_probe}) begin
                n_rem_p = CFG_W'(trial_p - {1'b0, r_probe});
            end else begin
                n_rem_p = CFG_W'(trial_p);
            end
        end

        if (i_cmd.fin) begin
            n_need_div = 1'b0;
            n_res_ka   = (r_keepalive != '0) && (r_rem_k == '0);
            if (r_probe != '0 && !r_probe_out && r_rem_p == '0) begin
                n_res_pr     = 1'b1;
                n_probe_out  = 1'b1;
                n_activity   = 1'b0;
                n_probe_wait = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle       <= '0;
            r_rekey_pend <= 1'b0;
            r_probe_out  <= 1'b0;
            r_activity   <= 1'b0;
            r_probe_wait <= '0;
            r_stopped    <= 1'b0;
            r_need_div   <= 1'b0;
        end else begin
            r_idle       <= n_idle;
            r_rekey_pend <= n_rekey_pend;
            r_probe_out  <= n_probe_out;
            r_activity   <= n_activity;
            r_probe_wait <= n_probe_wait;
            r_stopped    <= n_stopped;
            r_need_div   <= n_need_div;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_kind      <= n_kind;
        r_bit       <= n_bit;
        r_rem_k     <= n_rem_k;
        r_rem_p     <= n_rem_p;
        r_res_ka    <= n_res_ka;
        r_res_pr    <= n_res_pr;
        r_res_reply <= n_res_reply;
        r_res_code  <= n_res_code;
    end

    // output register
    logic                       r_out_valid;
    logic                       r_o_ka;
    logic                       r_o_pr;
    logic                       r_o_reply;
    logic                       r_o_ended;
    logic [tlw_pkg::CODE_W-1:0] r_o_code;
    logic                       r_o_reconn;
    logic                       r_o_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_ka      <= r_res_ka;
            r_o_pr      <= r_res_pr;
            r_o_reply   <= r_res_reply;
            r_o_ended   <= (r_res_code != tlw_pkg::END_NONE);
            r_o_code    <= r_res_code;
            r_o_reconn  <= (r_res_code == tlw_pkg::END_REKEY_UNSUPP)
                        || (r_res_code == tlw_pkg::END_REKEY_RECONN)
                        || (r_res_code == tlw_pkg::END_DEAD_PEER);
            r_o_stopped <= r_stopped;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_send_keepalive     = r_o_ka;
    assign o_send_probe         = r_o_pr;
    assign o_send_probe_reply   = r_o_reply;
    assign o_session_ended      = r_o_ended;
    assign o_end_code           = r_o_code;
    assign o_reconnect_eligible = r_o_reconn;
    assign o_is_stopped         = r_o_stopped;

    assign o_status.need_div = r_need_div;
    assign o_status.div_last = (r_bit == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

`ifndef NO_ASSERTIONS
    a_wait_needs_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_probe_wait != '0) |-> r_probe_out)
        else $error("probe wait count without outstanding probe");

    a_reconn_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_reconn) |-> r_o_ended)
        else $error("reconnect flag on a transaction that does not end the session");

    a_end_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_ended) |-> (!r_o_ka && !r_o_pr && r_o_stopped))
        else $error("ending transaction sends a frame or is not stopped");

    a_div_only_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_req == tlw_pkg::REQ_POLL && !r_stopped))
        else $error("remainder step outside an idle poll");
`endif

endmodule

@@ src/tunnel_liveness_watchdog.sv @@
`timescale 1ns / 1ps
// an idle poll that reaches the keepalive and probe checks is loaded, evaluated, run through
// the bit-serial remainder (one dividend bit a cycle) and finished before its result is ready
// other items skip the remainder and finish steps; a result waits until the output is free
// the next item is accepted in the cycle after the result is loaded, none while one is in flight
// reset: synchronous active-low i_rst_n clears configuration, session state and output valid

module tunnel_liveness_watchdog #(
    parameter int COUNT_BITS = tlw_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tlw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tlw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tlw_pkg::REQ_W-1:0]     i_req_type,
    input  logic [tlw_pkg::KIND_W-1:0]    i_frame_kind,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_send_keepalive,
    output logic                          o_send_probe,
    output logic                          o_send_probe_reply,
    output logic                          o_session_ended,
    output logic [tlw_pkg::CODE_W-1:0]    o_end_code,
    output logic                          o_reconnect_eligible,
    output logic                          o_is_stopped
);

    tlw_pkg::t_cmd    cmd;
    tlw_pkg::t_status status;

    tlw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlw_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_req_type           (i_req_type),
        .i_frame_kind         (i_frame_kind),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_send_keepalive     (o_send_keepalive),
        .o_send_probe         (o_send_probe),
        .o_send_probe_reply   (o_send_probe_reply),
        .o_session_ended      (o_session_ended),
        .o_end_code           (o_end_code),
        .o_reconnect_eligible (o_reconnect_eligible),
        .o_is_stopped         (o_is_stopped)
    );

endmodule
